// ===== src/rlps_pkg.sv =====
// Package for the request limit priority scheduler.
// Payload structs, function and result codes, default sizes. No dependencies.
`default_nettype none
package rlps_pkg;

  localparam int PendingDepth = 32;
  localparam int LoadingSlots = 8;
  localparam int IdBits       = 16;
  localparam logic [3:0] LimitReset = 4'd8;

  typedef enum logic [1:0] {
    FUNC_SUBMIT   = 2'd0,
    FUNC_COMPLETE = 2'd1,
    FUNC_CANCEL   = 2'd2,
    FUNC_REFILL   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    KIND_STARTED   = 3'd0,
    KIND_QUEUED    = 3'd1,
    KIND_PROCESSED = 3'd2,
    KIND_DROPPED   = 3'd3,
    KIND_NOT_FOUND = 3'd4
  } kind_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [IdBits-1:0] request_id;
    logic signed [15:0] priority_req;
    logic              is_file;
  } req_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [IdBits-1:0] request_id_res;
    logic [3:0]        loading_count;
    logic [5:0]        pending_count;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [IdBits-1:0]  id;
    logic signed [15:0] pri;
    logic               loc;
  } entry_t;

endpackage
`default_nettype wire

// ===== src/request_limit_priority_scheduler_core.sv =====
// Top level of the request limit priority scheduler.
// Pending list memory, loading set, sequencer. Depends on rlps_pkg.
//
// Usage: request items arrive on req/req_valid/req_stall, results leave on
// res/res_valid/res_stall; a transfer happens when valid is high and stall
// low. cfg_we writes the concurrency limit from cfg_data (take effect on the
// next item; write only while idle).
// One item is taken at a time; req_stall is high from its transfer until
// its last result is loaded into the output register.
// Submit and complete pass through the dispatch and emit states before
// res_valid rises. Cancel makes one compaction pass over the pending memory.
// Each promotion scans the pending list and then compacts it, both through
// the single read port of the memory, once per started request.
// The output register holds a result while res_stall is high; the
// sequencer waits in its emit state until the register is free.
// Reset (rst, synchronous) empties the pending list and loading set and
// sets the limit to 8. No clearing pass is needed.
`default_nettype none
module request_limit_priority_scheduler_core #(
  parameter int PENDING_DEPTH = rlps_pkg::PendingDepth,
  parameter int LOADING_SLOTS = rlps_pkg::LoadingSlots
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire rlps_pkg::req_t req,
  input  wire logic          req_valid,
  output logic               req_stall,
  output rlps_pkg::res_t     res,
  output logic               res_valid,
  input  wire logic          res_stall,
  input  wire logic          cfg_we,
  input  wire logic [3:0]    cfg_data
);

  localparam int AW = $clog2(PENDING_DEPTH);
  localparam int PW = AW + 1;
  localparam int CW = $clog2(LOADING_SLOTS + 1);
  localparam int IB = rlps_pkg::IdBits;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_DISPATCH = 5'b00010,
    ST_SCAN     = 5'b00100,
    ST_COMPACT  = 5'b01000,
    ST_EMIT     = 5'b10000
  } state_t;

  state_t state;
  rlps_pkg::req_t item;
  logic [3:0] limit;
  logic [PW-1:0] pend_size;
  logic [LOADING_SLOTS-1:0] load_vld;
  logic [IB-1:0] load_id [LOADING_SLOTS];

  rlps_pkg::entry_t mem [PENDING_DEPTH];
  rlps_pkg::entry_t rd_data;
  logic [AW-1:0] rd_addr;
  logic rd_en;
  logic rd_vld;
  logic [PW-1:0] rd_rank;
  logic [PW-1:0] cnt;
  logic [PW-1:0] wr_ptr;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  rlps_pkg::entry_t wr_data;

  logic have;
  logic best_loc;
  logic signed [15:0] best_pri;
  logic [PW-1:0] best_rank;
  logic [IB-1:0] best_id;
  logic cancel_mode;
  logic found;

  // result staged for the emit state
  logic [2:0] st_kind;
  logic [IB-1:0] st_id;
  logic st_chain;

  logic [CW-1:0] load_cnt;
  logic [CW-1:0] eff_lim;
  logic can_promote;
  logic [CW-1:0] lim_ext;
  logic [LOADING_SLOTS-1:0] free_onehot;
  logic [LOADING_SLOTS-1:0] match_vec;
  logic emit_last;
  logic out_free;
  logic scan_take;
  logic skip;

  assign load_cnt = CW'($countones(load_vld));
  assign lim_ext = (32'(limit) > LOADING_SLOTS) ? CW'(LOADING_SLOTS) : CW'(limit);
  assign eff_lim = lim_ext;
  assign can_promote = (load_cnt < eff_lim) && (pend_size != '0);
  assign out_free = !res_valid || !res_stall;
  assign emit_last = st_chain ? !can_promote : 1'b1;
  assign req_stall = (state != ST_IDLE);

  always_comb begin
    logic taken;
    taken = 1'b0;
    free_onehot = '0;
    for (int i = 0; i < LOADING_SLOTS; i++) begin
      if (!load_vld[i] && !taken) begin
        free_onehot[i] = 1'b1;
        taken = 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < LOADING_SLOTS; i++) begin
      match_vec[i] = load_vld[i] && (load_id[i] == item.request_id);
    end
  end

  assign scan_take = (!have || (rd_data.pri >= best_pri)) && (rd_data.loc || !best_loc);
  assign skip = cancel_mode ? (rd_data.id == item.request_id) : (rd_rank == best_rank);

  // memory read issue: scan and compaction walk ranks 0..size-1
  assign rd_en = ((state == ST_SCAN) || (state == ST_COMPACT)) && (cnt < pend_size);
  assign rd_addr = cnt[AW-1:0];

  always_comb begin
    wr_en = 1'b0;
    wr_addr = wr_ptr[AW-1:0];
    wr_data = rd_data;
    if ((state == ST_COMPACT) && rd_vld && !skip) begin
      wr_en = 1'b1;
    end
    if ((state == ST_DISPATCH) && (item.func == rlps_pkg::FUNC_SUBMIT) &&
        !(load_cnt < eff_lim) && (32'(pend_size) < PENDING_DEPTH)) begin
      wr_en = 1'b1;
      wr_addr = pend_size[AW-1:0];
      wr_data.id = item.request_id;
      wr_data.pri = item.priority_req;
      wr_data.loc = item.is_file;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      limit <= rlps_pkg::LimitReset;
      pend_size <= '0;
      load_vld <= '0;
      res_valid <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_data;
      end
      // the emit state reloads the register itself
      if (res_valid && !res_stall && (state != ST_EMIT)) begin
        res_valid <= 1'b0;
      end
      rd_vld <= rd_en;
      rd_rank <= cnt;
      if (rd_en) begin
        cnt <= cnt + 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            item <= req;
            state <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          case (item.func)
            rlps_pkg::FUNC_SUBMIT: begin
              st_id <= item.request_id;
              st_chain <= 1'b0;
              state <= ST_EMIT;
              if (load_cnt < eff_lim) begin
                for (int i = 0; i < LOADING_SLOTS; i++) begin
                  if (free_onehot[i]) begin
                    load_vld[i] <= 1'b1;
                    load_id[i] <= item.request_id;
                  end
                end
                st_kind <= rlps_pkg::KIND_STARTED;
              end else if (32'(pend_size) < PENDING_DEPTH) begin
                pend_size <= pend_size + 1'b1;
                st_kind <= rlps_pkg::KIND_QUEUED;
              end else begin
                st_kind <= rlps_pkg::KIND_DROPPED;
              end
            end
            rlps_pkg::FUNC_COMPLETE: begin
              st_id <= item.request_id;
              state <= ST_EMIT;
              load_vld <= load_vld & ~match_vec;
              st_kind <= (match_vec != '0) ? rlps_pkg::KIND_PROCESSED
                                           : rlps_pkg::KIND_NOT_FOUND;
              st_chain <= 1'b1;
            end
            rlps_pkg::FUNC_CANCEL: begin
              cancel_mode <= 1'b1;
              found <= 1'b0;
              cnt <= '0;
              wr_ptr <= '0;
              state <= ST_COMPACT;
            end
            default: begin
              if (can_promote) begin
                cnt <= '0;
                have <= 1'b0;
                best_loc <= 1'b0;
                state <= ST_SCAN;
              end else begin
                st_kind <= rlps_pkg::KIND_PROCESSED;
                st_id <= '0;
                st_chain <= 1'b1;
                state <= ST_EMIT;
              end
            end
          endcase
        end
        ST_SCAN: begin
          if (rd_vld && scan_take) begin
            have <= 1'b1;
            best_pri <= rd_data.pri;
            best_loc <= rd_data.loc;
            best_rank <= rd_rank;
            best_id <= rd_data.id;
          end
          if (!rd_en && !rd_vld) begin
            cancel_mode <= 1'b0;
            found <= 1'b0;
            cnt <= '0;
            wr_ptr <= '0;
            state <= ST_COMPACT;
          end
        end
        ST_COMPACT: begin
          if (rd_vld) begin
            if (skip) begin
              found <= 1'b1;
            end else begin
              wr_ptr <= wr_ptr + 1'b1;
            end
          end
          if (!rd_en && !rd_vld) begin
            pend_size <= wr_ptr;
            state <= ST_EMIT;
            if (cancel_mode) begin
              st_kind <= found ? rlps_pkg::KIND_PROCESSED : rlps_pkg::KIND_NOT_FOUND;
              st_id <= item.request_id;
              st_chain <= 1'b0;
            end else begin
              for (int i = 0; i < LOADING_SLOTS; i++) begin
                if (free_onehot[i]) begin
                  load_vld[i] <= 1'b1;
                  load_id[i] <= best_id;
                end
              end
              st_kind <= rlps_pkg::KIND_STARTED;
              st_id <= best_id;
              st_chain <= 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            res_valid <= 1'b1;
            res.kind <= st_kind;
            res.request_id_res <= st_id;
            res.loading_count <= 4'(load_cnt);
            res.pending_count <= 6'(pend_size);
            res.last <= emit_last;
            if (emit_last) begin
              state <= ST_IDLE;
            end else begin
              cnt <= '0;
              have <= 1'b0;
              best_loc <= 1'b0;
              state <= ST_SCAN;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    32'(pend_size) <= PENDING_DEPTH)
    else $error("pending count above depth");

  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMPACT) |-> (wr_ptr <= cnt))
    else $error("compaction write pointer ahead of read pointer");

  a_start_limit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_free && st_kind == rlps_pkg::KIND_STARTED)
      |=> (32'(res.loading_count) <= 32'(eff_lim)))
    else $error("start issued above the concurrency limit");

  a_no_promote_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (pend_size != '0))
    else $error("promotion scan on empty pending list");

endmodule
`default_nettype wire
